// ===== sv/awic_pkg.sv =====
// ---------------------------------------------------------------------------
// awic_pkg: shared constants for the affine warp inverse-compose pipeline
// Default word format and the lane order of the four matrix terms.
// ---------------------------------------------------------------------------
`default_nettype none

package awic_pkg;

  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;

  // four quotient lanes: C00, C01, C10, C11
  localparam int NumLanes = 4;
  localparam int LaneC00  = 0;
  localparam int LaneC01  = 1;
  localparam int LaneC10  = 2;
  localparam int LaneC11  = 3;

endpackage

`default_nettype wire

// ===== sv/awic_front.sv =====
// ---------------------------------------------------------------------------
// awic_front: matrix setup, determinant and numerators
// Five stages: I+J with saturation, products, differences, determinant
// rounding with numerator magnitudes, divisor magnitude and sign.
// ---------------------------------------------------------------------------
`default_nettype none

module awic_front
  import awic_pkg::*;
#(
  parameter int W = WordBitsDef,
  parameter int F = FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ld_i,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic [W-1:0]               cur_tx_i,
  input  logic [W-1:0]               cur_ty_i,
  input  logic [W-1:0]               cur_dudx_i,
  input  logic [W-1:0]               cur_dudy_i,
  input  logic [W-1:0]               cur_dvdx_i,
  input  logic [W-1:0]               cur_dvdy_i,
  input  logic [W-1:0]               inc_tx_i,
  input  logic [W-1:0]               inc_ty_i,
  input  logic [W-1:0]               inc_dudx_i,
  input  logic [W-1:0]               inc_dudy_i,
  input  logic [W-1:0]               inc_dvdx_i,
  input  logic [W-1:0]               inc_dvdy_i,
  output logic                       valid_o,
  output logic [2*W:0]               num_o [NumLanes],
  output logic [2*W-F:0]             den_o,
  output logic [4*W+NumLanes+1:0]    side_o
);

  localparam int NW = 2 * W + 1;
  localparam int DW = NW - F;
  localparam logic signed [W:0]    One  = (W + 1)'(1) << F;
  localparam logic signed [NW-1:0] Half = NW'(1) << (F - 1);

  // {overflow, value}; overflow seen in the top two bits of a W+1 sum
  function automatic logic [W:0] sat1(input logic signed [W:0] x);
    if (x[W] != x[W-1]) begin
      return {1'b1, x[W], {(W - 1){~x[W]}}};
    end
    return {1'b0, x[W-1:0]};
  endfunction

  logic [4:0] v_q;

  // stage 1
  logic [W:0]          sa00, sa11, sb00, sb11;
  logic signed [W-1:0] a_q [4];
  logic signed [W-1:0] b_q [4];
  logic [4*W-1:0]      tr1_q;
  logic                ov1_q;

  always_comb begin
    sa00 = sat1($signed({cur_dudx_i[W-1], cur_dudx_i}) + One);
    sa11 = sat1($signed({cur_dvdy_i[W-1], cur_dvdy_i}) + One);
    sb00 = sat1($signed({inc_dudx_i[W-1], inc_dudx_i}) + One);
    sb11 = sat1($signed({inc_dvdy_i[W-1], inc_dvdy_i}) + One);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      a_q[0] <= sa00[W-1:0];
      a_q[1] <= cur_dudy_i;
      a_q[2] <= cur_dvdx_i;
      a_q[3] <= sa11[W-1:0];
      b_q[0] <= sb00[W-1:0];
      b_q[1] <= inc_dudy_i;
      b_q[2] <= inc_dvdx_i;
      b_q[3] <= sb11[W-1:0];
      tr1_q  <= {inc_ty_i, inc_tx_i, cur_ty_i, cur_tx_i};
      ov1_q  <= sa00[W] | sa11[W] | sb00[W] | sb11[W];
    end
  end

  // stage 2: products
  logic signed [2*W-1:0] pd_q [2];
  logic signed [2*W-1:0] pn_q [8];
  logic [4*W-1:0]        tr2_q;
  logic                  ov2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q[0] <= b_q[0] * b_q[3];
      pd_q[1] <= b_q[1] * b_q[2];
      pn_q[0] <= a_q[0] * b_q[3];
      pn_q[1] <= a_q[1] * b_q[2];
      pn_q[2] <= a_q[1] * b_q[0];
      pn_q[3] <= a_q[0] * b_q[1];
      pn_q[4] <= a_q[2] * b_q[3];
      pn_q[5] <= a_q[3] * b_q[2];
      pn_q[6] <= a_q[3] * b_q[0];
      pn_q[7] <= a_q[2] * b_q[1];
      tr2_q   <= tr1_q;
      ov2_q   <= ov1_q;
    end
  end

  // stage 3: differences, exact
  logic signed [NW-1:0] dd_q;
  logic signed [NW-1:0] n_q [NumLanes];
  logic [4*W-1:0]       tr3_q;
  logic                 ov3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q <= NW'(pd_q[0]) - NW'(pd_q[1]);
      for (int l = 0; l < NumLanes; l++) begin
        n_q[l] <= NW'(pn_q[2*l]) - NW'(pn_q[2*l+1]);
      end
      tr3_q <= tr2_q;
      ov3_q <= ov2_q;
    end
  end

  // stage 4: round determinant, numerator magnitudes
  logic signed [NW-1:0] dr;
  logic signed [DW-1:0] det_q;
  logic [NW-1:0]        nm4_d [NumLanes];
  logic [NW-1:0]        nm4_q [NumLanes];
  logic [NumLanes-1:0]  nsg_q;
  logic [4*W-1:0]       tr4_q;
  logic                 ov4_q;

  always_comb begin
    dr = (dd_q + Half) >>> F;
    for (int l = 0; l < NumLanes; l++) begin
      nm4_d[l] = n_q[l][NW-1] ? NW'(-n_q[l]) : n_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= dr[DW-1:0];
      nm4_q <= nm4_d;
      for (int l = 0; l < NumLanes; l++) begin
        nsg_q[l] <= n_q[l][NW-1];
      end
      tr4_q <= tr3_q;
      ov4_q <= ov3_q;
    end
  end

  // stage 5: divisor magnitude, quotient signs, singular check
  logic [DW-1:0]       dmag_q;
  logic [NW-1:0]       nm5_q [NumLanes];
  logic [NumLanes-1:0] neg_q;
  logic                sing_q;
  logic [4*W-1:0]      tr5_q;
  logic                ov5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q <= det_q[DW-1] ? DW'(-det_q) : det_q;
      nm5_q  <= nm4_q;
      neg_q  <= nsg_q ^ {NumLanes{det_q[DW-1]}};
      sing_q <= (det_q == '0);
      tr5_q  <= tr4_q;
      ov5_q  <= ov4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld_i) begin
        v_q[0] <= in_valid_i;
      end
      if (en_i) begin
        v_q[4:1] <= v_q[3:0];
      end
    end
  end

  assign valid_o = v_q[4];
  assign num_o   = nm5_q;
  assign den_o   = dmag_q;
  assign side_o  = {sing_q, ov5_q, neg_q, tr5_q};

endmodule

`default_nettype wire

// ===== sv/awic_div.sv =====
// ---------------------------------------------------------------------------
// awic_div: pipelined restoring divider, four lanes on a shared divisor
// Range check stage, one quotient bit per stage, then a round-half-up stage.
// ---------------------------------------------------------------------------
`default_nettype none

module awic_div
  import awic_pkg::*;
#(
  parameter int W  = WordBitsDef,
  parameter int F  = FracBitsDef,
  parameter int SW = 4 * WordBitsDef + NumLanes + 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*W:0]        num_i [NumLanes],
  input  logic [2*W-F:0]      den_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [W:0]          quo_o [NumLanes],
  output logic [NumLanes-1:0] ovf_o,
  output logic [SW-1:0]       side_o
);

  localparam int NW = 2 * W + 1;
  localparam int DW = NW - F;
  localparam int XW = NW + W + 1;

  logic [W+1:0]        v_q;
  logic [NW-1:0]       rem_d [W+1][NumLanes];
  logic [NW-1:0]       rem_q [W+1][NumLanes];
  logic [W-1:0]        qb_d  [W+1][NumLanes];
  logic [W-1:0]        qb_q  [W+1][NumLanes];
  logic [NumLanes-1:0] ov_d  [W+1];
  logic [NumLanes-1:0] ov_q  [W+1];
  logic [DW-1:0]       den_q [W+1];
  logic [SW-1:0]       side_q [W+2];
  logic [W:0]          quo_d [NumLanes];
  logic [W:0]          quo_q [NumLanes];
  logic [NumLanes-1:0] ovf_q;

  always_comb begin
    logic [XW-1:0] dsh;
    logic [XW-1:0] rx;
    logic          up;
    // quotient must fit in W bits, otherwise the lane saturates
    for (int l = 0; l < NumLanes; l++) begin
      rem_d[0][l] = num_i[l];
      qb_d[0][l]  = '0;
      ov_d[0][l]  = XW'(num_i[l]) >= (XW'(den_i) << W);
    end
    for (int s = 1; s <= W; s++) begin
      for (int l = 0; l < NumLanes; l++) begin
        dsh = XW'(den_q[s-1]) << (W - s);
        rx  = XW'(rem_q[s-1][l]);
        if (rx >= dsh) begin
          rem_d[s][l] = NW'(rx - dsh);
          qb_d[s][l]  = {qb_q[s-1][l][W-2:0], 1'b1};
        end else begin
          rem_d[s][l] = rem_q[s-1][l];
          qb_d[s][l]  = {qb_q[s-1][l][W-2:0], 1'b0};
        end
      end
      ov_d[s] = ov_q[s-1];
    end
    // round to nearest: bump when twice the remainder reaches the divisor
    for (int l = 0; l < NumLanes; l++) begin
      up       = (XW'(rem_q[W][l]) << 1) >= XW'(den_q[W]);
      quo_d[l] = {1'b0, qb_q[W][l]} + (W + 1)'(up);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q    <= rem_d;
      qb_q     <= qb_d;
      ov_q     <= ov_d;
      den_q[0] <= den_i;
      side_q[0] <= side_i;
      for (int s = 1; s <= W; s++) begin
        den_q[s] <= den_q[s-1];
      end
      for (int s = 1; s <= W + 1; s++) begin
        side_q[s] <= side_q[s-1];
      end
      quo_q <= quo_d;
      ovf_q <= ov_q[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[W:0], valid_i};
    end
  end

  assign valid_o = v_q[W+1];
  assign quo_o   = quo_q;
  assign ovf_o   = ovf_q;
  assign side_o  = side_q[W+1];

endmodule

`default_nettype wire

// ===== sv/awic_back.sv =====
// ---------------------------------------------------------------------------
// awic_back: quotient saturation and translation update
// Three stages: signed C terms, C*dt products and C-1, rounded sums;
// final subtract and saturation feed the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module awic_back
  import awic_pkg::*;
#(
  parameter int W  = WordBitsDef,
  parameter int F  = FracBitsDef,
  parameter int SW = 4 * WordBitsDef + NumLanes + 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [W:0]          quo_i [NumLanes],
  input  logic [NumLanes-1:0] ovf_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [W-1:0]        new_tx_o,
  output logic [W-1:0]        new_ty_o,
  output logic [W-1:0]        new_dudx_o,
  output logic [W-1:0]        new_dudy_o,
  output logic [W-1:0]        new_dvdx_o,
  output logic [W-1:0]        new_dvdy_o,
  output logic                singular_o,
  output logic                overflow_o
);

  localparam int BW = 2 * W + 3;
  localparam logic signed [BW-1:0] SatHi = {{(BW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [BW-1:0] SatLo = ~SatHi;
  localparam logic signed [BW-1:0] One   = BW'(1) << F;
  localparam logic signed [BW-1:0] Half  = BW'(1) << (F - 1);

  // {overflow, value}
  function automatic logic [W:0] sat_w(input logic signed [BW-1:0] x);
    if (x > SatHi) begin
      return {1'b1, SatHi[W-1:0]};
    end
    if (x < SatLo) begin
      return {1'b1, SatLo[W-1:0]};
    end
    return {1'b0, x[W-1:0]};
  endfunction

  logic [2:0] v_q;

  logic [NumLanes-1:0] neg;
  assign neg = side_i[4*W+NumLanes-1:4*W];

  // stage 1: signed, saturated C terms
  logic [W:0]          cs [NumLanes];
  logic signed [W-1:0] c_q [NumLanes];
  logic [4*W-1:0]      tr1_q;
  logic                ov1_q, sg1_q;

  always_comb begin
    logic signed [BW-1:0] mag;
    for (int l = 0; l < NumLanes; l++) begin
      mag = BW'(quo_i[l]);
      if (ovf_i[l]) begin
        cs[l] = neg[l] ? {1'b1, SatLo[W-1:0]} : {1'b1, SatHi[W-1:0]};
      end else begin
        cs[l] = sat_w(neg[l] ? -mag : mag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        c_q[l] <= cs[l][W-1:0];
      end
      tr1_q <= side_i[4*W-1:0];
      ov1_q <= side_i[4*W+NumLanes] | cs[LaneC00][W] | cs[LaneC01][W]
             | cs[LaneC10][W] | cs[LaneC11][W];
      sg1_q <= side_i[4*W+NumLanes+1];
    end
  end

  // stage 2: C*dt products, diagonal minus one
  logic signed [W-1:0]   itx, ity;
  logic [W:0]            dx_s, dy_s;
  logic signed [2*W-1:0] pr_q [NumLanes];
  logic [W-1:0]          dudx_q, dudy_q, dvdx_q, dvdy_q;
  logic [2*W-1:0]        cur2_q;
  logic                  ov2_q, sg2_q;

  assign itx  = tr1_q[3*W-1:2*W];
  assign ity  = tr1_q[4*W-1:3*W];
  assign dx_s = sat_w(BW'(c_q[LaneC00]) - One);
  assign dy_s = sat_w(BW'(c_q[LaneC11]) - One);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q[0] <= c_q[LaneC00] * itx;
      pr_q[1] <= c_q[LaneC01] * ity;
      pr_q[2] <= c_q[LaneC10] * itx;
      pr_q[3] <= c_q[LaneC11] * ity;
      dudx_q  <= dx_s[W-1:0];
      dudy_q  <= c_q[LaneC01];
      dvdx_q  <= c_q[LaneC10];
      dvdy_q  <= dy_s[W-1:0];
      cur2_q  <= tr1_q[2*W-1:0];
      ov2_q   <= ov1_q | dx_s[W] | dy_s[W];
      sg2_q   <= sg1_q;
    end
  end

  // stage 3: each product rounded on its own, then summed
  logic signed [BW-1:0] rr [NumLanes];
  logic signed [BW-1:0] s0_q, s1_q;
  logic [W-1:0]         dudx3_q, dudy3_q, dvdx3_q, dvdy3_q;
  logic [2*W-1:0]       cur3_q;
  logic                 ov3_q, sg3_q;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      rr[l] = (BW'(pr_q[l]) + Half) >>> F;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q    <= rr[0] + rr[1];
      s1_q    <= rr[2] + rr[3];
      dudx3_q <= dudx_q;
      dudy3_q <= dudy_q;
      dvdx3_q <= dvdx_q;
      dvdy3_q <= dvdy_q;
      cur3_q  <= cur2_q;
      ov3_q   <= ov2_q;
      sg3_q   <= sg2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  logic signed [W-1:0] ctx, cty;
  logic [W:0]          tx_s, ty_s;

  assign ctx  = cur3_q[W-1:0];
  assign cty  = cur3_q[2*W-1:W];
  assign tx_s = sat_w(BW'(ctx) - s0_q);
  assign ty_s = sat_w(BW'(cty) - s1_q);

  // singular increment: zeros, no overflow
  always_comb begin
    if (sg3_q) begin
      new_tx_o   = '0;
      new_ty_o   = '0;
      new_dudx_o = '0;
      new_dudy_o = '0;
      new_dvdx_o = '0;
      new_dvdy_o = '0;
      overflow_o = 1'b0;
    end else begin
      new_tx_o   = tx_s[W-1:0];
      new_ty_o   = ty_s[W-1:0];
      new_dudx_o = dudx3_q;
      new_dudy_o = dudy3_q;
      new_dvdx_o = dvdx3_q;
      new_dvdy_o = dvdy3_q;
      overflow_o = ov3_q | tx_s[W] | ty_s[W];
    end
  end

  assign singular_o = sg3_q;
  assign valid_o    = v_q[2];

endmodule

`default_nettype wire

// ===== sv/affine_warp_inverse_compose_top.sv =====
// From input word to output word: 5 front stages, WORD_BITS + 2 divider stages,
//   3 back stages, output register; the bit-per-stage divider sets the depth.
// Throughput: one word per cycle while the output register is not stalled.
// The pipeline advances while the output register is empty or being taken;
// the first stage also fills whenever it is empty.
// Reset clears all valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// affine_warp_inverse_compose_top: inverse-compositional affine warp update
// Inverts the increment matrix through its determinant, composes with the
// current warp and updates the translation, with saturation and flags.
// ---------------------------------------------------------------------------
`default_nettype none

module affine_warp_inverse_compose_top
  import awic_pkg::*;
#(
  parameter int WORD_BITS = WordBitsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] cur_tx_i,
  input  logic [WORD_BITS-1:0] cur_ty_i,
  input  logic [WORD_BITS-1:0] cur_dudx_i,
  input  logic [WORD_BITS-1:0] cur_dudy_i,
  input  logic [WORD_BITS-1:0] cur_dvdx_i,
  input  logic [WORD_BITS-1:0] cur_dvdy_i,
  input  logic [WORD_BITS-1:0] inc_tx_i,
  input  logic [WORD_BITS-1:0] inc_ty_i,
  input  logic [WORD_BITS-1:0] inc_dudx_i,
  input  logic [WORD_BITS-1:0] inc_dudy_i,
  input  logic [WORD_BITS-1:0] inc_dvdx_i,
  input  logic [WORD_BITS-1:0] inc_dvdy_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] new_tx_o,
  output logic [WORD_BITS-1:0] new_ty_o,
  output logic [WORD_BITS-1:0] new_dudx_o,
  output logic [WORD_BITS-1:0] new_dudy_o,
  output logic [WORD_BITS-1:0] new_dvdx_o,
  output logic [WORD_BITS-1:0] new_dvdy_o,
  output logic                 singular_o,
  output logic                 overflow_o
);

  localparam int W  = WORD_BITS;
  localparam int SW = 4 * W + NumLanes + 2;

  logic en, ld, front_v;

  logic [2*W:0]           num   [NumLanes];
  logic [2*W-FRAC_BITS:0] den;
  logic [SW-1:0]          side_f, side_d;
  logic                   div_v, back_v;
  logic [W:0]             quo   [NumLanes];
  logic [NumLanes-1:0]    ovf;
  logic [W-1:0]           b_tx, b_ty, b_dudx, b_dudy, b_dvdx, b_dvdy;
  logic                   b_sing, b_ovf;

  logic                   out_valid_q;
  logic [W-1:0]           tx_q, ty_q, dudx_q, dudy_q, dvdx_q, dvdy_q;
  logic                   sing_q, ovf_q;
  logic                   fv_first;

  assign en = !out_valid_q || out_ready_i;
  assign ld = en || !fv_first;
  assign in_ready_o = ld;

  awic_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (ld),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .cur_tx_i   (cur_tx_i),
    .cur_ty_i   (cur_ty_i),
    .cur_dudx_i (cur_dudx_i),
    .cur_dudy_i (cur_dudy_i),
    .cur_dvdx_i (cur_dvdx_i),
    .cur_dvdy_i (cur_dvdy_i),
    .inc_tx_i   (inc_tx_i),
    .inc_ty_i   (inc_ty_i),
    .inc_dudx_i (inc_dudx_i),
    .inc_dudy_i (inc_dudy_i),
    .inc_dvdx_i (inc_dvdx_i),
    .inc_dvdy_i (inc_dvdy_i),
    .valid_o    (front_v),
    .num_o      (num),
    .den_o      (den),
    .side_o     (side_f)
  );

  // first-stage occupancy, tracked here to let an empty head fill under stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_first <= 1'b0;
    end else if (ld) begin
      fv_first <= in_valid_i;
    end
  end

  awic_div #(.W(W), .F(FRAC_BITS), .SW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .num_i   (num),
    .den_i   (den),
    .side_i  (side_f),
    .valid_o (div_v),
    .quo_o   (quo),
    .ovf_o   (ovf),
    .side_o  (side_d)
  );

  awic_back #(.W(W), .F(FRAC_BITS), .SW(SW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (div_v),
    .quo_i      (quo),
    .ovf_i      (ovf),
    .side_i     (side_d),
    .valid_o    (back_v),
    .new_tx_o   (b_tx),
    .new_ty_o   (b_ty),
    .new_dudx_o (b_dudx),
    .new_dudy_o (b_dudy),
    .new_dvdx_o (b_dvdx),
    .new_dvdy_o (b_dvdy),
    .singular_o (b_sing),
    .overflow_o (b_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= back_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q   <= b_tx;
      ty_q   <= b_ty;
      dudx_q <= b_dudx;
      dudy_q <= b_dudy;
      dvdx_q <= b_dvdx;
      dvdy_q <= b_dvdy;
      sing_q <= b_sing;
      ovf_q  <= b_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_tx_o    = tx_q;
  assign new_ty_o    = ty_q;
  assign new_dudx_o  = dudx_q;
  assign new_dudy_o  = dudy_q;
  assign new_dvdx_o  = dvdx_q;
  assign new_dvdy_o  = dvdy_q;
  assign singular_o  = sing_q;
  assign overflow_o  = ovf_q;

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> new_tx_o == '0 && new_ty_o == '0 &&
      new_dudx_o == '0 && new_dudy_o == '0 && new_dvdx_o == '0 &&
      new_dvdy_o == '0 && !overflow_o)
    else $error("singular word with nonzero fields");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side is free");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && fv_first |=> fv_first)
    else $error("first stage word lost during stall");

endmodule

`default_nettype wire

// ===== sim/tb_affine_warp_inverse_compose_top.sv =====
// ---------------------------------------------------------------------------
// tb_affine_warp_inverse_compose_top: self-checking bench for the warp update
// Streams current/increment warp pairs through the pipeline under random and
// forced back-pressure. Each output word is checked against a bit-exact
// fixed-point model of the inverse-compose update.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_affine_warp_inverse_compose_top;
  import awic_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WB        = WordBitsDef;
  localparam int  FB        = FracBitsDef;
  localparam int  NumIn     = 12;
  localparam int  NumOut    = 6;
  localparam int  NumRandom = 1750;
  localparam int  StallLimit = 5000;
  localparam int  HoldCycles = 400;
  localparam int  DrainCycles = 80;
  localparam logic [WB-1:0] One = 1 << FB;

  // input lane order
  localparam int FCurTx = 0, FCurTy = 1, FCurDudx = 2, FCurDudy = 3, FCurDvdx = 4;
  localparam int FCurDvdy = 5, FIncTx = 6, FIncTy = 7, FIncDudx = 8, FIncDudy = 9;
  localparam int FIncDvdx = 10, FIncDvdy = 11;

  typedef logic [WB-1:0] word_t;
  typedef struct {
    word_t f[NumIn];
  } warp_pair_t;
  typedef struct {
    word_t w[NumOut];
    logic  sing;
    logic  ovf;
  } warp_upd_t;

  class warp_scoreboard;
    warp_upd_t pending_upd[$];
    int        errors;
    int        checked;
    int        n_sing;
    int        n_ovf;

    function longint sat_word(longint x, inout bit ovf);
      longint hi, lo;
      hi = (64'sd1 <<< (WB - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
        ovf = 1;
        return hi;
      end
      if (x < lo) begin
        ovf = 1;
        return lo;
      end
      return x;
    endfunction

    function longint round_frac(longint x);
      return (x + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function longint div_nearest(longint n, longint d);
      bit neg;
      longint unsigned un, ud, q, r, maxpos;
      neg    = (n < 0) != (d < 0);
      un     = (n < 0) ? 64'd0 - n : n;
      ud     = (d < 0) ? 64'd0 - d : d;
      q      = un / ud;
      r      = un % ud;
      maxpos = 64'h7FFF_FFFF_FFFF_FFFF;
      if (r >= ud - r) q++;
      if (!neg && q > maxpos) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (neg && q > maxpos + 1) return 64'sh8000_0000_0000_0000;
      return neg ? longint'(64'd0 - q) : longint'(q);
    endfunction

    function warp_upd_t compose_update(warp_pair_t p);
      warp_upd_t u;
      longint v[NumIn];
      longint one, a00, a01, a10, a11, b00, b01, b10, b11, det;
      longint c00, c01, c10, c11, s0, s1;
      bit ovf;
      ovf = 0;
      one = longint'(One);
      foreach (v[i]) v[i] = longint'(signed'(p.f[i]));
      a00 = sat_word(one + v[FCurDudx], ovf);
      a01 = v[FCurDudy];
      a10 = v[FCurDvdx];
      a11 = sat_word(one + v[FCurDvdy], ovf);
      b00 = sat_word(one + v[FIncDudx], ovf);
      b01 = v[FIncDudy];
      b10 = v[FIncDvdx];
      b11 = sat_word(one + v[FIncDvdy], ovf);
      det = round_frac(b00 * b11 - b01 * b10);
      if (det == 0) begin
        foreach (u.w[i]) u.w[i] = '0;
        u.sing = 1;
        u.ovf  = 0;
        return u;
      end
      c00 = sat_word(div_nearest(a00 * b11 - a01 * b10, det), ovf);
      c01 = sat_word(div_nearest(a01 * b00 - a00 * b01, det), ovf);
      c10 = sat_word(div_nearest(a10 * b11 - a11 * b10, det), ovf);
      c11 = sat_word(div_nearest(a11 * b00 - a10 * b01, det), ovf);
      s0  = round_frac(c00 * v[FIncTx]) + round_frac(c01 * v[FIncTy]);
      s1  = round_frac(c10 * v[FIncTx]) + round_frac(c11 * v[FIncTy]);
      u.w[0] = word_t'(sat_word(v[FCurTx] - s0, ovf));
      u.w[1] = word_t'(sat_word(v[FCurTy] - s1, ovf));
      u.w[2] = word_t'(sat_word(c00 - one, ovf));
      u.w[3] = word_t'(c01);
      u.w[4] = word_t'(c10);
      u.w[5] = word_t'(sat_word(c11 - one, ovf));
      u.sing = 0;
      u.ovf  = ovf;
      return u;
    endfunction

    function void note_pair(warp_pair_t p);
      pending_upd.push_back(compose_update(p));
    endfunction

    function void check_upd(warp_upd_t got);
      warp_upd_t exp_u;
      bit bad;
      if (pending_upd.size() == 0) begin
        $display("%0t: unexpected output word, nothing pending", $realtime);
        errors++;
        return;
      end
      exp_u = pending_upd.pop_front();
      checked++;
      bad = 0;
      foreach (got.w[i])
        if (got.w[i] !== exp_u.w[i]) begin
          $display("%0t: field %0d exp %h got %h", $realtime, i, exp_u.w[i], got.w[i]);
          bad = 1;
        end
      if (got.sing !== exp_u.sing || got.ovf !== exp_u.ovf) begin
        $display("%0t: flags sing/ovf exp %b%b got %b%b", $realtime,
                 exp_u.sing, exp_u.ovf, got.sing, got.ovf);
        bad = 1;
      end
      if (bad) errors++;
      if (exp_u.sing) n_sing++;
      if (exp_u.ovf) n_ovf++;
    endfunction
  endclass

  logic  clk_i = 0;
  logic  rst_ni = 0;
  logic  in_valid_i = 0;
  logic  in_ready_o;
  word_t in_word [NumIn];
  logic  out_valid_o;
  logic  out_ready_i = 0;
  word_t out_word [NumOut];
  logic  singular_o, overflow_o;

  warp_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  quiet_cycles;

  initial foreach (in_word[i]) in_word[i] = '0;

  affine_warp_inverse_compose_top dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .cur_tx_i(in_word[FCurTx]), .cur_ty_i(in_word[FCurTy]),
    .cur_dudx_i(in_word[FCurDudx]), .cur_dudy_i(in_word[FCurDudy]),
    .cur_dvdx_i(in_word[FCurDvdx]), .cur_dvdy_i(in_word[FCurDvdy]),
    .inc_tx_i(in_word[FIncTx]), .inc_ty_i(in_word[FIncTy]),
    .inc_dudx_i(in_word[FIncDudx]), .inc_dudy_i(in_word[FIncDudy]),
    .inc_dvdx_i(in_word[FIncDvdx]), .inc_dvdy_i(in_word[FIncDvdy]),
    .out_valid_o, .out_ready_i,
    .new_tx_o(out_word[0]), .new_ty_o(out_word[1]),
    .new_dudx_o(out_word[2]), .new_dudy_o(out_word[3]),
    .new_dvdx_o(out_word[4]), .new_dvdy_o(out_word[5]),
    .singular_o, .overflow_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // sample on the edge; all bench drives are nonblocking so values are pre-edge
  always @(posedge clk_i) begin
    warp_pair_t p;
    warp_upd_t  u;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        foreach (p.f[i]) p.f[i] = in_word[i];
        sb.note_pair(p);
      end
      if (out_valid_o && out_ready_i) begin
        foreach (u.w[i]) u.w[i] = out_word[i];
        u.sing = singular_o;
        u.ovf  = overflow_o;
        sb.check_upd(u);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: timeout, no word moved for %0d cycles", $realtime, StallLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_pair(warp_pair_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    foreach (p.f[i]) in_word[i] <= p.f[i];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic word_t srand_word(int span);
    return word_t'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic warp_pair_t make_random_pair();
    warp_pair_t p;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < NumIn; i++) begin
      if (i == FCurTx || i == FCurTy || i == FIncTx || i == FIncTy)
        p.f[i] = srand_word(64 << FB);
      else
        p.f[i] = srand_word(One / 2);
    end
    case (mode)
      0, 1: foreach (p.f[i]) p.f[i] = $urandom();
      2: begin
        // zero first row of B
        p.f[FIncDudx] = -One;
        p.f[FIncDudy] = '0;
      end
      3: begin
        // near-degenerate B: tiny diagonal, tiny off-diagonal
        p.f[FIncDudx] = -One + $urandom_range(0, 600);
        p.f[FIncDvdy] = -One + $urandom_range(0, 600);
        p.f[FIncDudy] = srand_word(300);
        p.f[FIncDvdx] = srand_word(300);
      end
      4: p.f[$urandom_range(0, NumIn - 1)] = $urandom();
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    warp_pair_t d[$];
    warp_pair_t p;
    send_idle_pct = 24;
    recv_idle_pct = 55;
    hold_req      = 0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (p.f[i]) p.f[i] = '0;
    d.push_back(p);                                     // identity on both sides
    foreach (p.f[i]) p.f[i] = 32'h7FFF_FFFF;
    d.push_back(p);
    foreach (p.f[i]) p.f[i] = 32'h8000_0000;
    d.push_back(p);
    foreach (p.f[i]) p.f[i] = 32'hAAAA_AAAA;
    d.push_back(p);
    foreach (p.f[i]) p.f[i] = 32'h5555_5555;
    d.push_back(p);
    foreach (p.f[i]) p.f[i] = '0;
    p.f[FIncDudx] = -One;                               // exactly singular
    d.push_back(p);
    p.f[FIncDudx] = -One + 1;                           // det below half an lsb
    p.f[FIncDvdy] = -One + 1;
    d.push_back(p);
    p.f[FIncDudx] = -One + 256;                         // det of one lsb, huge C
    p.f[FIncDvdy] = -One + 256;
    p.f[FIncTx]   = 5 << FB;
    d.push_back(p);
    foreach (p.f[i]) p.f[i] = '0;
    p.f[FIncDudx] = -2 * One;                           // negative determinant
    p.f[FIncTx]   = 3 << FB;
    p.f[FIncTy]   = -(7 << FB);
    p.f[FCurTx]   = 32'h7FFF_0000;
    d.push_back(p);
    p.f[FCurDudx] = 32'h7FFF_FFFF;                      // A saturates
    p.f[FCurDvdy] = 32'h8000_0000;
    d.push_back(p);
    foreach (p.f[i]) p.f[i] = '0;
    p.f[FIncDudy] = One;                                // pure off-diagonal terms
    p.f[FIncDvdx] = -One;
    p.f[FCurDudy] = One / 3;
    p.f[FIncTy]   = 1;
    d.push_back(p);
    foreach (d[i]) send_pair(d[i]);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 600) begin
        send_idle_pct = 55;
        recv_idle_pct = 24;
      end
      if (n == 1200) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1;
      end
      send_pair(make_random_pair());
    end
    in_valid_i <= 1'b0;

    while (sb.pending_upd.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d warp updates (%0d singular, %0d saturated) under mixed stalls",
             sb.checked, sb.n_sing, sb.n_ovf);
    if (sb.errors == 0 && sb.pending_upd.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
